// ===== rtl/ppp_pkg.sv =====
// Shared types and constants for the point-to-polyline proximity block.
`default_nettype none

package ppp_pkg;

  // result distance width, 2^-20 m^2 units
  localparam int DIST_W = 49;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // configuration registers
  localparam int RADIUS_W  = 13;
  localparam int THR_W     = 2 * RADIUS_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PED_RADIUS   = 1'd1;

  // multiplier operand sources
  localparam int SRC_W = 3;
  localparam logic [SRC_W-1:0] SRC_SX = 3'd0;
  localparam logic [SRC_W-1:0] SRC_SY = 3'd1;
  localparam logic [SRC_W-1:0] SRC_DX = 3'd2;
  localparam logic [SRC_W-1:0] SRC_DY = 3'd3;
  localparam logic [SRC_W-1:0] SRC_EX = 3'd4;
  localparam logic [SRC_W-1:0] SRC_EY = 3'd5;
  localparam logic [SRC_W-1:0] SRC_CH = 3'd6;
  localparam logic [SRC_W-1:0] SRC_CL = 3'd7;

  // accumulator operations
  localparam int MOP_W = 2;
  localparam logic [MOP_W-1:0] MOP_CLR = 2'd0;
  localparam logic [MOP_W-1:0] MOP_ADD = 2'd1;
  localparam logic [MOP_W-1:0] MOP_SUB = 2'd2;
  localparam logic [MOP_W-1:0] MOP_SHL = 2'd3;

  typedef struct packed {
    logic             en;
    logic [SRC_W-1:0] a_sel;
    logic [SRC_W-1:0] b_sel;
    logic [MOP_W-1:0] op;
    logic             dbl;
  } ppp_mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ppp_mac.sv =====
// Shared multiply-accumulate unit with its segment operand registers.
`default_nettype none

module ppp_mac import ppp_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           load,
  input  wire logic signed [COORD_BITS-1:0]   vertex_x,
  input  wire logic signed [COORD_BITS-1:0]   vertex_y,
  input  wire logic signed [COORD_BITS-1:0]   prev_x,
  input  wire logic signed [COORD_BITS-1:0]   prev_y,
  input  wire logic signed [COORD_BITS-1:0]   query_x,
  input  wire logic signed [COORD_BITS-1:0]   query_y,
  input  wire ppp_mac_ctl_t                   ctl,
  input  wire logic                           cmag_load,
  output logic signed [4*COORD_BITS+3:0]      acc
);

  localparam int DW   = COORD_BITS + 1;
  localparam int OPW  = COORD_BITS + 2;
  localparam int PW   = 2 * OPW;
  localparam int ACCW = 4 * COORD_BITS + 4;
  localparam int CMW  = 2 * COORD_BITS + 2;
  localparam int SH   = COORD_BITS + 1;

  logic signed [DW-1:0]   sx_r, sy_r, dx_r, dy_r, ex_r, ey_r;
  logic [CMW-1:0]         cmag_r;
  logic signed [OPW-1:0]  op_a, op_b;
  logic signed [PW-1:0]   p_r;
  ppp_mac_ctl_t           ctl_r;
  logic signed [ACCW-1:0] acc_r, acc_nxt, acc_abs, prod_ext, term;
  logic signed [OPW-1:0]  ch_op, cl_op;

  assign ch_op = $signed(OPW'(cmag_r[CMW-1:SH]));
  assign cl_op = $signed(OPW'(cmag_r[SH-1:0]));

  always_comb begin
    case (ctl.a_sel)
      SRC_SX:  op_a = OPW'(sx_r);
      SRC_SY:  op_a = OPW'(sy_r);
      SRC_DX:  op_a = OPW'(dx_r);
      SRC_DY:  op_a = OPW'(dy_r);
      SRC_EX:  op_a = OPW'(ex_r);
      SRC_EY:  op_a = OPW'(ey_r);
      SRC_CH:  op_a = ch_op;
      SRC_CL:  op_a = cl_op;
      default: op_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      SRC_SX:  op_b = OPW'(sx_r);
      SRC_SY:  op_b = OPW'(sy_r);
      SRC_DX:  op_b = OPW'(dx_r);
      SRC_DY:  op_b = OPW'(dy_r);
      SRC_EX:  op_b = OPW'(ex_r);
      SRC_EY:  op_b = OPW'(ey_r);
      SRC_CH:  op_b = ch_op;
      SRC_CL:  op_b = cl_op;
      default: op_b = '0;
    endcase
  end

  assign prod_ext = ACCW'(p_r);
  assign term     = ctl_r.dbl ? (prod_ext <<< 1) : prod_ext;
  assign acc_abs  = acc_r[ACCW-1] ? -acc_r : acc_r;

  // product is registered; the accumulate step follows in the cycle after
  always_comb begin
    case (ctl_r.op)
      MOP_CLR: acc_nxt = term;
      MOP_ADD: acc_nxt = acc_r + term;
      MOP_SUB: acc_nxt = acc_r - term;
      MOP_SHL: acc_nxt = (acc_r <<< SH) + term;
      default: acc_nxt = acc_r;
    endcase
    if (!ctl_r.en) acc_nxt = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sx_r <= DW'(vertex_x) - DW'(prev_x);
      sy_r <= DW'(vertex_y) - DW'(prev_y);
      dx_r <= DW'(query_x) - DW'(prev_x);
      dy_r <= DW'(query_y) - DW'(prev_y);
      ex_r <= DW'(query_x) - DW'(vertex_x);
      ey_r <= DW'(query_y) - DW'(vertex_y);
    end
    if (cmag_load) cmag_r <= acc_abs[CMW-1:0];
    p_r   <= op_a * op_b;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/ppp_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating quotient.
`default_nettype none

module ppp_div import ppp_pkg::*; #(
  parameter int NUMW = 99,
  parameter int DENW = 50
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUMW-1:0]   num,
  input  wire logic [DENW-1:0]   den,
  output logic                   busy,
  output logic [DIST_W-1:0]      quo
);

  localparam int HIW  = NUMW - DIST_W;
  localparam int CMPW = (HIW > DENW) ? HIW : DENW;
  localparam int CNTW = $clog2(DIST_W + 1);

  logic              busy_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DENW-1:0]   rem_r, den_r;
  logic [DIST_W-1:0] lo_r, quo_r;
  logic [CMPW-1:0]   hi_ext, den_ext;
  logic              ovf, ge;
  logic [DENW:0]     trial, diff;

  // quotient would need more than DIST_W bits
  assign hi_ext  = CMPW'(num[NUMW-1:DIST_W]);
  assign den_ext = CMPW'(den);
  assign ovf     = hi_ext >= den_ext;

  assign trial = {rem_r, lo_r[DIST_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= !ovf;
    end else if (busy_r && cnt_r == CNTW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      cnt_r <= CNTW'(DIST_W);
      rem_r <= hi_ext[DENW-1:0];
      lo_r  <= num[DIST_W-1:0];
      quo_r <= ovf ? DIST_MAX : '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
      lo_r  <= {lo_r[DIST_W-2:0], 1'b0};
      quo_r <= {quo_r[DIST_W-2:0], ge};
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/point_to_polyline_proximity.sv =====
// Point-to-polyline proximity top level: sequencer, path state and result word.
// Path vertices come in one word at a time; the word flagged first_vertex also
// carries the query point. For every segment the block computes the squared
// distance from the point to the segment on one shared multiply-accumulate
// unit and a bit-serial divider, and keeps the minimum. A word flagged
// last_vertex produces one result word with the minimum and the on-path flag
// (minimum <= robot radius^2 + pedestrian radius^2). The divider that forms
// the perpendicular distance has 49 steps; a zero-length segment or a point
// on the start vertex ends the segment before the divide, and a saturated
// quotient skips the divide steps. in_stall stays high while a segment is in
// work and while a result word waits for the output register; a finished
// result word sits in the output register and does not hold off the next
// input word. Radius writes are taken at any time and must only be made
// while the block is idle.
`default_nettype none

module point_to_polyline_proximity import ppp_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  in_person_x,
  input  wire logic signed [COORD_BITS-1:0]  in_person_y,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_x,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_y,
  input  wire logic                          in_first_vertex,
  input  wire logic                          in_last_vertex,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_on_path,
  output logic                               out_distance_found,
  output logic [DIST_W-1:0]                  out_min_sq_dist,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [RADIUS_W-1:0]           cfg_data
);

  localparam int DENW = 2 * COORD_BITS + 2;
  localparam int ACCW = 4 * COORD_BITS + 4;
  localparam int NUMW = ACCW - 1;
  localparam int SATW = (DENW > DIST_W) ? DENW : DIST_W;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
  localparam logic [ST_W-1:0] ST_SS0  = 5'd1;
  localparam logic [ST_W-1:0] ST_SS1  = 5'd2;
  localparam logic [ST_W-1:0] ST_DD0  = 5'd3;
  localparam logic [ST_W-1:0] ST_DD1  = 5'd4;
  localparam logic [ST_W-1:0] ST_CR0  = 5'd5;
  localparam logic [ST_W-1:0] ST_CR1  = 5'd6;
  localparam logic [ST_W-1:0] ST_CW   = 5'd7;
  localparam logic [ST_W-1:0] ST_CM   = 5'd8;
  localparam logic [ST_W-1:0] ST_SQ0  = 5'd9;
  localparam logic [ST_W-1:0] ST_SQ1  = 5'd10;
  localparam logic [ST_W-1:0] ST_SQ2  = 5'd11;
  localparam logic [ST_W-1:0] ST_DS0  = 5'd12;
  localparam logic [ST_W-1:0] ST_DS1  = 5'd13;
  localparam logic [ST_W-1:0] ST_DSW  = 5'd14;
  localparam logic [ST_W-1:0] ST_DSC  = 5'd15;
  localparam logic [ST_W-1:0] ST_E0   = 5'd16;
  localparam logic [ST_W-1:0] ST_E1   = 5'd17;
  localparam logic [ST_W-1:0] ST_EW   = 5'd18;
  localparam logic [ST_W-1:0] ST_EC   = 5'd19;
  localparam logic [ST_W-1:0] ST_DIVW = 5'd20;
  localparam logic [ST_W-1:0] ST_SEL  = 5'd21;
  localparam logic [ST_W-1:0] ST_UPD  = 5'd22;
  localparam logic [ST_W-1:0] ST_OUT  = 5'd23;

  logic [ST_W-1:0] state_r, state_nxt, fin_state;

  logic signed [COORD_BITS-1:0] query_x_r, query_y_r, prev_x_r, prev_y_r;
  logic [DIST_W-1:0]   best_r, cand_r;
  logic                have_best_r, finished_early_r, have_prev_r, last_r;
  logic [DENW-1:0]     dotss_r, dotdd_r, e_r;
  logic                ds_neg_r, ds_gt_r;
  logic [RADIUS_W-1:0] robot_radius_r, ped_radius_r;
  logic [2*RADIUS_W-1:0] rr_sq, pr_sq;
  logic [THR_W-1:0]    thr_r;

  logic                out_valid_r, out_on_path_r, out_found_r;
  logic [DIST_W-1:0]   out_dist_r;

  ppp_mac_ctl_t        mac_ctl;
  logic                cmag_load, div_start, div_busy;
  logic signed [ACCW-1:0] mac_acc;
  logic [DIST_W-1:0]   div_quo;

  logic                accept, seg_go, acc_zero, out_free, pass1, e_hit, upd_ok;
  logic [SATW-1:0]     dd_ext, e_ext;
  logic [DIST_W-1:0]   dd_sat, e_sat;

  function automatic ppp_mac_ctl_t mac_op(input logic [SRC_W-1:0] a,
                                          input logic [SRC_W-1:0] b,
                                          input logic [MOP_W-1:0] op,
                                          input logic             dbl);
    ppp_mac_ctl_t c;
    c.en    = 1'b1;
    c.a_sel = a;
    c.b_sel = b;
    c.op    = op;
    c.dbl   = dbl;
    return c;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign seg_go    = have_prev_r && !finished_early_r && !in_first_vertex;
  assign acc_zero  = mac_acc == '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_state = last_r ? ST_OUT : ST_IDLE;

  assign dd_ext = SATW'(dotdd_r);
  assign e_ext  = SATW'(e_r);
  assign dd_sat = (dd_ext > SATW'(DIST_MAX)) ? DIST_MAX : dd_ext[DIST_W-1:0];
  assign e_sat  = (e_ext > SATW'(DIST_MAX)) ? DIST_MAX : e_ext[DIST_W-1:0];

  // perpendicular candidate must beat the best before the endpoint check
  assign pass1  = !have_best_r || div_quo < best_r;
  assign e_hit  = !ds_neg_r && ds_gt_r && e_r == '0;
  assign upd_ok = !have_best_r || cand_r < best_r;

  assign rr_sq = robot_radius_r * robot_radius_r;
  assign pr_sq = ped_radius_r * ped_radius_r;

  ppp_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .vertex_x  (in_vertex_x),
    .vertex_y  (in_vertex_y),
    .prev_x    (prev_x_r),
    .prev_y    (prev_y_r),
    .query_x   (query_x_r),
    .query_y   (query_y_r),
    .ctl       (mac_ctl),
    .cmag_load (cmag_load),
    .acc       (mac_acc)
  );

  ppp_div #(
    .NUMW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mac_acc[NUMW-1:0]),
    .den   (dotss_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // MAC products and controls are registered ahead of the accumulator, so captures trail their ops
  always_comb begin
    state_nxt = state_r;
    mac_ctl   = '0;
    cmag_load = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (seg_go) state_nxt = ST_SS0;
          else if (in_last_vertex) state_nxt = ST_OUT;
        end
      end
      ST_SS0: begin
        mac_ctl   = mac_op(SRC_SX, SRC_SX, MOP_CLR, 1'b0);
        state_nxt = ST_SS1;
      end
      ST_SS1: begin
        mac_ctl   = mac_op(SRC_SY, SRC_SY, MOP_ADD, 1'b0);
        state_nxt = ST_DD0;
      end
      ST_DD0: begin
        mac_ctl   = mac_op(SRC_DX, SRC_DX, MOP_CLR, 1'b0);
        state_nxt = ST_DD1;
      end
      ST_DD1: begin
        mac_ctl   = mac_op(SRC_DY, SRC_DY, MOP_ADD, 1'b0);
        state_nxt = acc_zero ? fin_state : ST_CR0;
      end
      ST_CR0: begin
        mac_ctl   = mac_op(SRC_SX, SRC_DY, MOP_CLR, 1'b0);
        state_nxt = ST_CR1;
      end
      ST_CR1: begin
        mac_ctl   = mac_op(SRC_SY, SRC_DX, MOP_SUB, 1'b0);
        state_nxt = acc_zero ? fin_state : ST_CW;
      end
      ST_CW: begin
        state_nxt = ST_CM;
      end
      ST_CM: begin
        cmag_load = 1'b1;
        state_nxt = ST_SQ0;
      end
      ST_SQ0: begin
        mac_ctl   = mac_op(SRC_CH, SRC_CH, MOP_CLR, 1'b0);
        state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        mac_ctl   = mac_op(SRC_CH, SRC_CL, MOP_SHL, 1'b1);
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        mac_ctl   = mac_op(SRC_CL, SRC_CL, MOP_SHL, 1'b0);
        state_nxt = ST_DS0;
      end
      ST_DS0: begin
        mac_ctl   = mac_op(SRC_DX, SRC_SX, MOP_CLR, 1'b0);
        state_nxt = ST_DS1;
      end
      ST_DS1: begin
        mac_ctl   = mac_op(SRC_DY, SRC_SY, MOP_ADD, 1'b0);
        div_start = 1'b1;
        state_nxt = ST_DSW;
      end
      ST_DSW: begin
        state_nxt = ST_DSC;
      end
      ST_DSC: begin
        state_nxt = ST_E0;
      end
      ST_E0: begin
        mac_ctl   = mac_op(SRC_EX, SRC_EX, MOP_CLR, 1'b0);
        state_nxt = ST_E1;
      end
      ST_E1: begin
        mac_ctl   = mac_op(SRC_EY, SRC_EY, MOP_ADD, 1'b0);
        state_nxt = ST_EW;
      end
      ST_EW: begin
        state_nxt = ST_EC;
      end
      ST_EC: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (!div_busy) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        state_nxt = (!pass1 || e_hit) ? fin_state : ST_UPD;
      end
      ST_UPD: begin
        state_nxt = fin_state;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      query_x_r        <= '0;
      query_y_r        <= '0;
      prev_x_r         <= '0;
      prev_y_r         <= '0;
      best_r           <= '0;
      have_best_r      <= 1'b0;
      finished_early_r <= 1'b0;
      have_prev_r      <= 1'b0;
      last_r           <= 1'b0;
      robot_radius_r   <= RADIUS_W'(471);
      ped_radius_r     <= RADIUS_W'(512);
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROBOT_RADIUS: robot_radius_r <= cfg_data;
          REG_PED_RADIUS:   ped_radius_r   <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        if (in_first_vertex) begin
          query_x_r        <= in_person_x;
          query_y_r        <= in_person_y;
          best_r           <= '0;
          have_best_r      <= 1'b0;
          finished_early_r <= 1'b0;
        end
        prev_x_r    <= in_vertex_x;
        prev_y_r    <= in_vertex_y;
        have_prev_r <= 1'b1;
        last_r      <= in_last_vertex;
      end

      // point on the start vertex, or on the end vertex past the projection
      if ((state_r == ST_CR1 && acc_zero) || (state_r == ST_SEL && pass1 && e_hit)) begin
        best_r           <= '0;
        have_best_r      <= 1'b1;
        finished_early_r <= 1'b1;
      end

      if (state_r == ST_UPD && upd_ok) begin
        best_r      <= cand_r;
        have_best_r <= 1'b1;
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    thr_r <= THR_W'(rr_sq) + THR_W'(pr_sq);
    if (state_r == ST_DD1) dotss_r <= mac_acc[DENW-1:0];
    if (state_r == ST_CR1) dotdd_r <= mac_acc[DENW-1:0];
    if (state_r == ST_DSC) begin
      ds_neg_r <= mac_acc[ACCW-1];
      ds_gt_r  <= mac_acc > $signed(ACCW'(dotss_r));
    end
    if (state_r == ST_EC) e_r <= mac_acc[DENW-1:0];
    if (state_r == ST_SEL) begin
      cand_r <= ds_neg_r ? dd_sat : (ds_gt_r ? e_sat : div_quo);
    end
    if (state_r == ST_OUT && out_free) begin
      out_found_r   <= have_best_r;
      out_on_path_r <= have_best_r && best_r <= DIST_W'(thr_r);
      out_dist_r    <= have_best_r ? best_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_on_path        = out_on_path_r;
  assign out_distance_found = out_found_r;
  assign out_min_sq_dist    = out_dist_r;

`ifndef NO_ASSERTIONS
  a_div_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r != ST_IDLE && state_r != ST_OUT)
    else $error("divider running outside a segment");

  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !have_best_r |-> best_r == '0)
    else $error("minimum held without a found distance");

  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    finished_early_r |-> have_best_r && best_r == '0)
    else $error("early finish without a zero minimum");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("result word not loaded on leaving output state");
`endif

endmodule

`default_nettype wire

// ===== bench/point_to_polyline_proximity_tb.sv =====
// Self-checking bench for the point-to-polyline proximity block.
`timescale 1ns / 1ps

module point_to_polyline_proximity_tb import ppp_pkg::*;;

  localparam int CW           = 24;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_LEN     = 1500;
  localparam longint LIMIT    = 2000000;

  typedef struct packed {
    logic              on_path;
    logic              found;
    logic [DIST_W-1:0] sq_dist;
  } proximity_t;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_person_x     = '0;
  logic signed [CW-1:0] in_person_y     = '0;
  logic signed [CW-1:0] in_vertex_x     = '0;
  logic signed [CW-1:0] in_vertex_y     = '0;
  logic                 in_first_vertex = 1'b0;
  logic                 in_last_vertex  = 1'b0;
  logic                 out_valid;
  logic                 out_stall       = 1'b1;
  logic                 out_on_path;
  logic                 out_distance_found;
  logic [DIST_W-1:0]    out_min_sq_dist;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_ROBOT_RADIUS;
  logic [RADIUS_W-1:0]  cfg_data        = '0;

  point_to_polyline_proximity dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_person_x        (in_person_x),
    .in_person_y        (in_person_y),
    .in_vertex_x        (in_vertex_x),
    .in_vertex_y        (in_vertex_y),
    .in_first_vertex    (in_first_vertex),
    .in_last_vertex     (in_last_vertex),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_on_path        (out_on_path),
    .out_distance_found (out_distance_found),
    .out_min_sq_dist    (out_min_sq_dist),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // path tracker: mirrors the block's path state, cleared as after reset
  longint            trk_qx = 0, trk_qy = 0, trk_px = 0, trk_py = 0;
  logic [DIST_W-1:0] trk_best      = '0;
  logic              trk_have_best = 1'b0;
  logic              trk_done      = 1'b0;
  logic              trk_have_prev = 1'b0;
  int                radius_robot  = 471;
  int                radius_person = 512;

  proximity_t expected_proximity[$];

  int     tx_idle_pct = 15;
  int     rx_idle_pct = 55;
  int     hold_reqs   = 0;
  int     hold_seen   = 0;
  int     hold_cycles = 0;
  logic   rx_hold     = 1'b0;
  int     mismatches  = 0;
  int     items_sent  = 0;
  int     reports_seen = 0;
  int     on_path_seen = 0;
  int     no_dist_seen = 0;
  int     radius_writes = 0;
  longint cycle_count = 0;

  function automatic logic [DIST_W-1:0] clip_dist(input longint v);
    if (v > longint'(DIST_MAX)) return DIST_MAX;
    return v[DIST_W-1:0];
  endfunction

  function automatic logic signed [CW-1:0] jitter(input logic signed [CW-1:0] c, input int bits);
    logic signed [CW-1:0] r;
    r = CW'($urandom());
    return c + (r >>> (CW - bits));
  endfunction

  task automatic mark_contact();
    trk_best      = '0;
    trk_have_best = 1'b1;
    trk_done      = 1'b1;
  endtask

  // squared distance from the query point to segment prev -> (x2, y2)
  task automatic close_segment(input longint x2, input longint y2);
    longint            sx, sy, dx, dy, c, seg_len2, pt_len2, along, ex, ey, end_len2;
    logic [127:0]      cmag, cross2;
    logic [DIST_W-1:0] cand;
    sx = x2 - trk_px;
    sy = y2 - trk_py;
    dx = trk_qx - trk_px;
    dy = trk_qy - trk_py;
    seg_len2 = sx * sx + sy * sy;
    if (seg_len2 == 0) return;
    pt_len2 = dx * dx + dy * dy;
    if (pt_len2 == 0) begin
      mark_contact();
      return;
    end
    c = sx * dy - sy * dx;
    cmag = (c < 0) ? -c : c;
    cross2 = cmag * cmag;
    if (cross2 >= (128'(seg_len2) << DIST_W)) cand = DIST_MAX;
    else cand = DIST_W'(cross2 / 128'(seg_len2));
    if (!trk_have_best || cand < trk_best) begin
      along = dx * sx + dy * sy;
      if (along < 0) begin
        cand = clip_dist(pt_len2);
      end else if (along > seg_len2) begin
        ex = trk_qx - x2;
        ey = trk_qy - y2;
        end_len2 = ex * ex + ey * ey;
        if (end_len2 == 0) begin
          mark_contact();
          return;
        end
        cand = clip_dist(end_len2);
      end
      if (!trk_have_best || cand < trk_best) begin
        trk_best      = cand;
        trk_have_best = 1'b1;
      end
    end
  endtask

  task automatic advance_path(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                              input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                              input logic first, input logic last);
    proximity_t r;
    longint     thr;
    if (first) begin
      trk_qx        = px;
      trk_qy        = py;
      trk_best      = '0;
      trk_have_best = 1'b0;
      trk_done      = 1'b0;
      trk_have_prev = 1'b0;
    end
    if (trk_have_prev && !trk_done) close_segment(vx, vy);
    trk_px        = vx;
    trk_py        = vy;
    trk_have_prev = 1'b1;
    if (last) begin
      thr       = longint'(radius_robot) * radius_robot + longint'(radius_person) * radius_person;
      r.found   = trk_have_best;
      r.sq_dist = trk_have_best ? trk_best : '0;
      r.on_path = trk_have_best && (longint'(r.sq_dist) <= thr);
      expected_proximity.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    mismatches++;
  endtask

  task automatic send_vertex(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                             input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                             input logic first, input logic last);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_person_x     <= px;
    in_person_y     <= py;
    in_vertex_x     <= vx;
    in_vertex_y     <= vy;
    in_first_vertex <= first;
    in_last_vertex  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_path(px, py, vx, vy, first, last);
    items_sent++;
  endtask

  // drop valid, let every report come back, then give the block time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_proximity.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [CFG_IDX_W-1:0] idx, input logic [RADIUS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ROBOT_RADIUS) radius_robot = val;
    else radius_person = val;
    radius_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_radii(input int robot, input int person);
    write_radius(REG_ROBOT_RADIUS, RADIUS_W'(robot));
    write_radius(REG_PED_RADIUS, RADIUS_W'(person));
  endtask

  // no first_vertex yet: query sits at the origin; a later word extends a closed path
  task automatic test_headless_path();
    send_vertex(123, -77, 1000, 500, 1'b0, 1'b0);
    send_vertex(0, 0, -1000, 500, 1'b0, 1'b1);
    send_vertex(0, 0, -1000, -2000, 1'b0, 1'b1);
  endtask

  task automatic test_short_paths();
    // lone vertex
    send_vertex(10, 10, 10, 10, 1'b1, 1'b1);
    // query on the start vertex, rest ignored
    send_vertex(7, 7, 7, 7, 1'b1, 1'b0);
    send_vertex(0, 0, 100, -50, 1'b0, 1'b0);
    send_vertex(0, 0, -300, -300, 1'b0, 1'b1);
    // zero-length segment, then a real one
    send_vertex(0, 3000, 10, 10, 1'b1, 1'b0);
    send_vertex(0, 0, 10, 10, 1'b0, 1'b0);
    send_vertex(0, 0, 500, 10, 1'b0, 1'b1);
    // query on the end vertex
    send_vertex(40, 40, -40, -40, 1'b1, 1'b0);
    send_vertex(0, 0, 40, 40, 1'b0, 1'b1);
    // projection before the start, then beyond the end
    send_vertex(-500, 20, 0, 0, 1'b1, 1'b0);
    send_vertex(0, 0, 1000, 0, 1'b0, 1'b1);
    send_vertex(1500, 20, 0, 0, 1'b1, 1'b0);
    send_vertex(0, 0, 1000, 0, 1'b0, 1'b1);
  endtask

  task automatic test_coordinate_extremes();
    send_vertex(CMAX, CMAX, CMIN, CMIN, 1'b1, 1'b0);
    send_vertex(CMIN, CMIN, CMIN, CMAX, 1'b0, 1'b0);
    send_vertex(CMIN, CMAX, CMAX, CMIN, 1'b0, 1'b1);
    send_vertex(CMIN, CMAX, CMAX, CMAX, 1'b1, 1'b0);
    send_vertex(CMAX, CMIN, CMIN, CMIN, 1'b0, 1'b1);
  endtask

  // threshold 3^2 + 4^2 = 25: distance 25 is on the path, 36 is not
  task automatic test_radius_threshold();
    settle();
    set_radii(3, 4);
    send_vertex(50, 5, 0, 0, 1'b1, 1'b0);
    send_vertex(0, 0, 100, 0, 1'b0, 1'b1);
    send_vertex(50, 6, 0, 0, 1'b1, 1'b0);
    send_vertex(0, 0, 100, 0, 1'b0, 1'b1);
    settle();
  endtask

  task automatic send_random_path();
    int                   len, bits, roll;
    logic signed [CW-1:0] qx, qy, cx, cy, vx, vy, px, py;
    roll = $urandom_range(0, 99);
    len = (roll < 5) ? 1 : (roll < 85) ? $urandom_range(2, 5) : $urandom_range(6, 12);
    case ($urandom_range(0, 3))
      0: bits = 8;
      1: bits = 12;
      2: bits = 18;
      default: bits = 24;
    endcase
    cx = CW'($urandom());
    cy = CW'($urandom());
    qx = jitter(cx, bits);
    qy = jitter(cy, bits);
    vx = jitter(cx, bits);
    vy = jitter(cy, bits);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (i > 0 && roll < 10) begin
        // repeat the previous vertex: zero-length segment
      end else if (roll < 16) begin
        vx = qx;
        vy = qy;
      end else begin
        vx = jitter(cx, bits);
        vy = jitter(cy, bits);
      end
      px = (i == 0) ? qx : CW'($urandom());
      py = (i == 0) ? qy : CW'($urandom());
      send_vertex(px, py, vx, vy, i == 0, i == len - 1);
    end
  endtask

  task automatic test_random_paths(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // stray words with arbitrary flags
        repeat ($urandom_range(1, 3))
          send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_random_path();
      end
    end
    settle();
  endtask

  // result side blocked for a long stretch while words keep coming
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    hold_reqs++;
    repeat (12) begin
      send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()),
                  1'b1, 1'b0);
      send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()),
                  1'b0, 1'b1);
    end
    settle();
  endtask

  // long receiver hold, counted here once requested
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_cycles <= HOLD_LEN;
      rx_hold     <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rx_hold     <= 1'b1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    proximity_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_proximity.size() == 0) begin
        report_mismatch("unexpected report", out_min_sq_dist, 0);
      end else begin
        want = expected_proximity.pop_front();
        if (want.on_path) on_path_seen++;
        if (!want.found) no_dist_seen++;
        if (out_on_path !== want.on_path)
          report_mismatch("on_path", out_on_path, want.on_path);
        if (out_distance_found !== want.found)
          report_mismatch("distance_found", out_distance_found, want.found);
        if (out_min_sq_dist !== want.sq_dist)
          report_mismatch("min_sq_dist", out_min_sq_dist, want.sq_dist);
      end
    end
    out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycle_count, expected_proximity.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 15;
    rx_idle_pct = 55;
    test_headless_path();
    test_short_paths();
    test_coordinate_extremes();
    test_radius_threshold();

    set_radii($urandom_range(0, 8191), $urandom_range(0, 2000));
    test_random_paths(380);

    test_output_backpressure();

    tx_idle_pct = 55;
    rx_idle_pct = 15;
    set_radii(8191, 8191);
    test_random_paths(380);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_radii(0, 0);
    test_random_paths(190);
    set_radii($urandom_range(0, 8191), $urandom_range(0, 8191));
    test_random_paths(190);

    $display("covered %0d vertex words and %0d distance reports (%0d on path, %0d empty)",
             items_sent, reports_seen, on_path_seen, no_dist_seen);
    $display("radius writes: %0d, mismatches: %0d", radius_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ppp_pkg.sv
rtl/ppp_mac.sv
rtl/ppp_div.sv
rtl/point_to_polyline_proximity.sv
bench/point_to_polyline_proximity_tb.sv
